/* rtl/sha1_pkg.sv */
// Shared constants, types and round functions for the SHA-1 engine.
package sha1_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned BlockBytes = 64;

  localparam logic [0:0] OP_DATA   = 1'b0;
  localparam logic [0:0] OP_FINISH = 1'b1;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [0:0] op;
    logic [7:0] data_byte;
  } cmd_t;

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] r;
    if (t < 7'd20) r = (b & c) | (~b & d);
    else if (t < 7'd40) r = b ^ c ^ d;
    else if (t < 7'd60) r = (b & c) | (b & d) | (c & d);
    else r = b ^ c ^ d;
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] r;
    if (t < 7'd20) r = K0;
    else if (t < 7'd40) r = K1;
    else if (t < 7'd60) r = K2;
    else r = K3;
    return r;
  endfunction

endpackage

/* rtl/sha1_front.sv */
// Input command queue between the stream port and the hash core.
module sha1_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha1_pkg::cmd_t      in_cmd,
  output logic                q_valid,
  input  logic                q_ready,
  output sha1_pkg::cmd_t      q_cmd
);
  import sha1_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t           slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            push;
  logic            pop;

  assign in_ready = (count != (PtrW+1)'(QueueDepth));
  assign q_valid  = (count != '0);
  assign q_cmd    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (PtrW+1)'(QueueDepth)) else $error("queue count overflow");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("queue count slip");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> !pop) else $error("pop from empty queue");
`endif

endmodule

/* rtl/sha1_core.sv */
// Block buffer, padding sequencer, 80-round compression and digest output.
module sha1_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  sha1_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    digest_word,
  output logic [2:0]     word_index,
  output logic           last_word
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]   state;
  logic [60:0]  byte_count;
  logic [5:0]   pos;
  logic [31:0]  h [5];
  logic [31:0]  a, b, c, d, e;
  logic [31:0]  w [16];
  logic [6:0]   t;
  logic         finishing;
  logic         second_pass;
  logic [2:0]   emit_idx;
  logic [63:0]  bit_len;
  logic [31:0]  w_new;
  logic [31:0]  w_cur;
  logic [31:0]  tmp;
  logic [7:0]   put_byte;
  logic         put_en;

  assign bit_len = {byte_count, 3'b000};
  assign w_cur   = (t < 7'd16) ? w[0] :
                   {w_new[30:0], w_new[31]};
  assign w_new   = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign tmp     = {a[26:0], a[31:27]} + round_f(t, b, c, d) + e + round_k(t) + w_cur;

  assign q_ready     = (state == S_IDLE);
  assign out_valid   = (state == S_EMIT);
  assign digest_word = h[emit_idx];
  assign word_index  = emit_idx;
  assign last_word   = (emit_idx == 3'd4);

  // byte insertion into word buffer at pos (big-endian in each word)
  always_comb begin
    put_en   = 1'b0;
    put_byte = 8'h00;
    if (state == S_IDLE && q_valid && q_cmd.op == OP_DATA) begin
      put_en = 1'b1;
      put_byte = q_cmd.data_byte;
    end else if (state == S_PAD) begin
      put_en = 1'b1;
      put_byte = second_pass ? 8'h00 : (finishing ? 8'h00 : PAD_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      byte_count  <= '0;
      pos         <= '0;
      finishing   <= 1'b0;
      second_pass <= 1'b0;
      emit_idx    <= '0;
      t           <= '0;
      h[0] <= H0_INIT; h[1] <= H1_INIT; h[2] <= H2_INIT;
      h[3] <= H3_INIT; h[4] <= H4_INIT;
    end else begin
      if (put_en) begin
        unique case (pos[1:0])
          2'd0: w[pos[5:2]][31:24] <= put_byte;
          2'd1: w[pos[5:2]][23:16] <= put_byte;
          2'd2: w[pos[5:2]][15:8]  <= put_byte;
          default: w[pos[5:2]][7:0] <= put_byte;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.op == OP_DATA) begin
              byte_count <= byte_count + 1'b1;
              pos <= pos + 1'b1;
              if (pos == 6'd63) begin
                state <= S_ROUND;
                t <= '0;
                a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
              end
            end else begin
              state <= S_PAD;
              second_pass <= 1'b0;
              finishing <= 1'b0;
            end
          end
        end
        S_PAD: begin
          // first pad byte is 0x80 (zero on the second pass); zeros follow up to byte 55, or to the end of the block
          finishing <= 1'b1;
          pos <= pos + 1'b1;
          if (pos == 6'd63) begin
            state <= S_ROUND;
            t <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end else if (pos == 6'd55 && !second_pass) begin
            state <= S_LEN;
          end else if (pos == 6'd55) begin
            state <= S_LEN;
          end
        end
        S_LEN: begin
          w[14] <= bit_len[63:32];
          w[15] <= bit_len[31:0];
          second_pass <= 1'b1;
          pos <= '0;
          state <= S_ROUND;
          t <= '0;
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_cur;
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
          t <= t + 1'b1;
          if (t == 7'd79) state <= S_FOLD;
        end
        S_FOLD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (!finishing) begin
            state <= S_IDLE;
          end else if (second_pass) begin
            state <= S_EMIT;
            emit_idx <= '0;
          end else begin
            // padding overflowed the block: zero block then length
            second_pass <= 1'b1;
            pos <= '0;
            state <= S_PAD;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == 3'd4) begin
              state <= S_IDLE;
              byte_count <= '0;
              pos <= '0;
              finishing <= 1'b0;
              second_pass <= 1'b0;
              h[0] <= H0_INIT; h[1] <= H1_INIT; h[2] <= H2_INIT;
              h[3] <= H3_INIT; h[4] <= H4_INIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> emit_idx <= 3'd4) else $error("digest index out of range");
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND && t == 7'd79 |=> state == S_FOLD) else $error("round count slip");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(emit_idx)) else $error("emit dropped");
`endif

endmodule

/* rtl/sha1_hash_engine.sv */
// Top level of the SHA-1 engine: input queue and hash core.
//   channel | dir | tdata                          | tuser/tlast
//   s_axis  | in  | [7:0] data_byte                | tuser: op
//   m_axis  | out | [31:0] digest_word,[34:32] idx | tlast: last_word
// A data byte is taken in S_IDLE; the 64th byte of a block starts the 80 rounds and the fold.
// Finish pads up to byte 56, writes the length, hashes the block, emits five digest words;
// from byte 56 up it pads and hashes this block first, then a padded block with the length.
// rst is synchronous and restores the standard initial hash values.
// A four-entry queue takes input while the core hashes or m_axis stalls, until it fills.
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast
);
  import sha1_pkg::*;

  cmd_t        in_cmd;
  cmd_t        q_cmd;
  logic        q_valid;
  logic        q_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  assign in_cmd.op        = s_axis_tuser;
  assign in_cmd.data_byte = s_axis_tdata;
  assign m_axis_tdata     = {5'b0, word_index, digest_word};

  sha1_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  sha1_core u_core (
    .clk, .rst,
    .q_valid, .q_ready, .q_cmd,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .digest_word, .word_index, .last_word(m_axis_tlast)
  );

endmodule
